/* rtl/gpib_hs_pkg.sv */
// ----------------------------------------------------------------------------
// gpib_hs_pkg
// Types, codes and the command decoder shared by the GPIB handshake engine.
// ----------------------------------------------------------------------------
package gpib_hs_pkg;

  // field widths
  localparam int unsigned KindW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SettleW = 10;
  localparam int unsigned EventW  = 3;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 10;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_TALK_MODE    = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SETTLE_TICKS = 1'd1;

  localparam logic [SettleW-1:0] SETTLE_RESET = 10'd10;

  // request kinds
  localparam logic [KindW-1:0] KIND_TICK   = 3'd0;
  localparam logic [KindW-1:0] KIND_CMD    = 3'd1;
  localparam logic [KindW-1:0] KIND_DATA   = 3'd2;
  localparam logic [KindW-1:0] KIND_FINISH = 3'd3;
  localparam logic [KindW-1:0] KIND_REJECT = 3'd4;
  localparam logic [KindW-1:0] KIND_SEND   = 3'd5;

  // command bytes and masks, logical polarity
  localparam logic [ByteW-1:0] BYTE_DCL     = 8'b0001_0100;
  localparam logic [ByteW-1:0] BYTE_SPE     = 8'b0001_1000;
  localparam logic [ByteW-1:0] BYTE_SPD     = 8'b0001_1001;
  localparam logic [ByteW-1:0] BYTE_UNL     = 8'b0011_1111;
  localparam logic [ByteW-1:0] BYTE_UNT     = 8'b0101_1111;
  localparam logic [ByteW-1:0] GROUP_MASK   = 8'b0110_0000;
  localparam logic [ByteW-1:0] GROUP_LISTEN = 8'b0010_0000;
  localparam logic [ByteW-1:0] GROUP_TALK   = 8'b0100_0000;
  localparam logic [ByteW-1:0] ADDR_MASK    = 8'b0001_1111;

  localparam logic [ByteW-1:0] BYTE_RELEASED = 8'hFF;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD    = 4'd1,
    PH_DATA   = 4'd2,
    PH_FINISH = 4'd3,
    PH_REJECT = 4'd4,
    PH_SETTLE = 4'd5,
    PH_READY  = 4'd6,
    PH_ACCEPT = 4'd7
  } phase_t;

  typedef enum logic [EventW-1:0] {
    EV_NONE     = 3'd0,
    EV_CMD      = 3'd1,
    EV_DATA     = 3'd2,
    EV_SENT     = 3'd3,
    EV_RELEASED = 3'd4
  } event_t;

  typedef enum logic [CmdW-1:0] {
    CMD_DCL     = 3'd0,
    CMD_SPE     = 3'd1,
    CMD_SPD     = 3'd2,
    CMD_UNL     = 3'd3,
    CMD_UNT     = 3'd4,
    CMD_MLA     = 3'd5,
    CMD_MTA     = 3'd6,
    CMD_UNKNOWN = 3'd7
  } cmd_t;

  // engine state
  typedef struct packed {
    phase_t             phase;
    logic [SettleW-1:0] settle_count;
    logic               ndac_level;
    logic               nrfd_level;
    logic               dav_level;
    logic               eoi_level;
    logic [ByteW-1:0]   data_drive;
    logic [ByteW-1:0]   latched_byte;
    logic               latched_atn;
    logic               latched_eoi;
  } state_t;

  // one sampled tick
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] dio_in;
    logic             atn_in;
    logic             dav_in;
    logic             ndac_in;
    logic             nrfd_in;
    logic             eoi_in;
    logic [ByteW-1:0] tx_byte;
    logic             tx_eoi;
  } item_t;

  // one result
  typedef struct packed {
    logic             ndac_drive;
    logic             nrfd_drive;
    logic             dav_drive;
    logic             eoi_drive;
    logic [ByteW-1:0] dio_drive;
    logic             busy_res;
    event_t           event_res;
    logic [ByteW-1:0] rx_value;
    logic             rx_atn_level;
    logic             rx_eoi_level;
    cmd_t             cmd_type;
    logic [AddrW-1:0] cmd_address;
  } result_t;

  // classify a command byte
  function automatic cmd_t decode_cmd(input logic [ByteW-1:0] v);
    cmd_t t;
    if (v == BYTE_DCL)                          t = CMD_DCL;
    else if (v == BYTE_SPE)                     t = CMD_SPE;
    else if (v == BYTE_SPD)                     t = CMD_SPD;
    else if (v == BYTE_UNL)                     t = CMD_UNL;
    else if (v == BYTE_UNT)                     t = CMD_UNT;
    else if ((v & GROUP_MASK) == GROUP_LISTEN)  t = CMD_MLA;
    else if ((v & GROUP_MASK) == GROUP_TALK)    t = CMD_MTA;
    else                                        t = CMD_UNKNOWN;
    return t;
  endfunction

  // state after reset or a mode change
  function automatic state_t released_state(input state_t s);
    state_t r;
    r              = s;
    r.phase        = PH_IDLE;
    r.settle_count = '0;
    r.ndac_level   = 1'b1;
    r.nrfd_level   = 1'b1;
    r.dav_level    = 1'b1;
    r.eoi_level    = 1'b1;
    r.data_drive   = BYTE_RELEASED;
    return r;
  endfunction

endpackage

/* rtl/gpib_hs_if.sv */
// ----------------------------------------------------------------------------
// gpib_hs_if
// Valid/ready channels for bus ticks in and handshake results out.
// ----------------------------------------------------------------------------
interface gpib_hs_in_if;
  logic                          valid;
  logic                          ready;
  logic [gpib_hs_pkg::KindW-1:0] kind;
  logic [gpib_hs_pkg::ByteW-1:0] dio_in;
  logic                          atn_in;
  logic                          dav_in;
  logic                          ndac_in;
  logic                          nrfd_in;
  logic                          eoi_in;
  logic [gpib_hs_pkg::ByteW-1:0] tx_byte;
  logic                          tx_eoi;

  modport source (
    output valid, kind, dio_in, atn_in, dav_in, ndac_in, nrfd_in, eoi_in,
           tx_byte, tx_eoi,
    input  ready
  );
  modport sink (
    input  valid, kind, dio_in, atn_in, dav_in, ndac_in, nrfd_in, eoi_in,
           tx_byte, tx_eoi,
    output ready
  );
endinterface

interface gpib_hs_out_if;
  logic                           valid;
  logic                           ready;
  logic                           ndac_drive;
  logic                           nrfd_drive;
  logic                           dav_drive;
  logic                           eoi_drive;
  logic [gpib_hs_pkg::ByteW-1:0]  dio_drive;
  logic                           busy_res;
  logic [gpib_hs_pkg::EventW-1:0] event_res;
  logic [gpib_hs_pkg::ByteW-1:0]  rx_value;
  logic                           rx_atn_level;
  logic                           rx_eoi_level;
  logic [gpib_hs_pkg::CmdW-1:0]   cmd_type;
  logic [gpib_hs_pkg::AddrW-1:0]  cmd_address;

  modport source (
    output valid, ndac_drive, nrfd_drive, dav_drive, eoi_drive, dio_drive,
           busy_res, event_res, rx_value, rx_atn_level, rx_eoi_level,
           cmd_type, cmd_address,
    input  ready
  );
  modport sink (
    input  valid, ndac_drive, nrfd_drive, dav_drive, eoi_drive, dio_drive,
           busy_res, event_res, rx_value, rx_atn_level, rx_eoi_level,
           cmd_type, cmd_address,
    output ready
  );
endinterface

/* rtl/gpib_hs_step.sv */
// ----------------------------------------------------------------------------
// gpib_hs_step
// Next-state and result logic of the handshake engine for one bus tick.
// ----------------------------------------------------------------------------
module gpib_hs_step (
  input  gpib_hs_pkg::state_t                  st,
  input  gpib_hs_pkg::item_t                   item,
  input  logic                                 talk_mode,
  input  logic [gpib_hs_pkg::SettleW-1:0]      settle_ticks,
  output gpib_hs_pkg::state_t                  st_next,
  output gpib_hs_pkg::result_t                 res
);

  gpib_hs_pkg::state_t   nxt;
  gpib_hs_pkg::event_t   evt;
  gpib_hs_pkg::cmd_t     ctype;
  logic [gpib_hs_pkg::AddrW-1:0] caddr;
  logic                  send_start;
  logic [gpib_hs_pkg::ByteW-1:0] rx_byte;

  assign rx_byte = ~item.dio_in;

  // request intake, then one pass of the active sequence
  always_comb begin
    nxt        = st;
    evt        = gpib_hs_pkg::EV_NONE;
    ctype      = gpib_hs_pkg::CMD_UNKNOWN;
    caddr      = '0;
    send_start = 1'b0;

    if (st.phase == gpib_hs_pkg::PH_IDLE) begin
      if (!talk_mode && (item.kind inside {[gpib_hs_pkg::KIND_CMD:gpib_hs_pkg::KIND_REJECT]}))
      begin
        case (item.kind)
          gpib_hs_pkg::KIND_CMD: begin
            nxt.phase = gpib_hs_pkg::PH_CMD;
          end
          gpib_hs_pkg::KIND_DATA: begin
            nxt.ndac_level = 1'b0;
            nxt.phase      = gpib_hs_pkg::PH_DATA;
          end
          gpib_hs_pkg::KIND_FINISH: begin
            nxt.nrfd_level = 1'b0;
            nxt.ndac_level = 1'b1;
            nxt.phase      = gpib_hs_pkg::PH_FINISH;
          end
          default: begin
            nxt.ndac_level = 1'b1;
            nxt.phase      = gpib_hs_pkg::PH_REJECT;
          end
        endcase
      end else if (talk_mode && item.kind == gpib_hs_pkg::KIND_SEND) begin
        // place byte and eoi, settle wait starts next tick
        nxt.eoi_level    = ~item.tx_eoi;
        nxt.data_drive   = ~item.tx_byte;
        nxt.settle_count = settle_ticks;
        nxt.phase        = gpib_hs_pkg::PH_SETTLE;
        send_start       = 1'b1;
      end
    end

    if (!send_start) begin
      case (nxt.phase)
        gpib_hs_pkg::PH_CMD: begin
          if (item.atn_in) begin
            nxt.ndac_level = 1'b1;
          end else begin
            nxt.ndac_level = 1'b0;
            if (!item.dav_in) begin
              nxt.nrfd_level   = 1'b0;
              nxt.latched_byte = rx_byte;
              ctype            = gpib_hs_pkg::decode_cmd(rx_byte);
              if (ctype == gpib_hs_pkg::CMD_MLA || ctype == gpib_hs_pkg::CMD_MTA) begin
                caddr = rx_byte[gpib_hs_pkg::AddrW-1:0];
              end
              evt       = gpib_hs_pkg::EV_CMD;
              nxt.phase = gpib_hs_pkg::PH_IDLE;
            end
          end
        end
        gpib_hs_pkg::PH_DATA: begin
          if (!item.dav_in) begin
            nxt.latched_byte = rx_byte;
            nxt.latched_atn  = item.atn_in;
            nxt.latched_eoi  = item.eoi_in;
            evt              = gpib_hs_pkg::EV_DATA;
            nxt.phase        = gpib_hs_pkg::PH_IDLE;
          end
        end
        gpib_hs_pkg::PH_FINISH: begin
          if (item.dav_in) begin
            nxt.ndac_level = 1'b0;
            nxt.nrfd_level = 1'b1;
            evt            = gpib_hs_pkg::EV_RELEASED;
            nxt.phase      = gpib_hs_pkg::PH_IDLE;
          end
        end
        gpib_hs_pkg::PH_REJECT: begin
          if (item.dav_in) begin
            nxt.nrfd_level = 1'b1;
            evt            = gpib_hs_pkg::EV_RELEASED;
            nxt.phase      = gpib_hs_pkg::PH_IDLE;
          end
        end
        gpib_hs_pkg::PH_SETTLE: begin
          if (nxt.settle_count != '0) begin
            nxt.settle_count = nxt.settle_count - 1'b1;
          end else if (!item.ndac_in && item.nrfd_in) begin
            nxt.dav_level = 1'b0;
            nxt.phase     = gpib_hs_pkg::PH_ACCEPT;
          end
        end
        gpib_hs_pkg::PH_ACCEPT: begin
          if (item.ndac_in) begin
            nxt.dav_level = 1'b1;
            nxt.eoi_level = 1'b1;
            evt           = gpib_hs_pkg::EV_SENT;
            nxt.phase     = gpib_hs_pkg::PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign st_next = nxt;

  // driven levels follow the mode, the rest reflects the new state
  always_comb begin
    res.ndac_drive   = talk_mode ? 1'b1 : nxt.ndac_level;
    res.nrfd_drive   = talk_mode ? 1'b1 : nxt.nrfd_level;
    res.dav_drive    = talk_mode ? nxt.dav_level : 1'b1;
    res.eoi_drive    = talk_mode ? nxt.eoi_level : 1'b1;
    res.dio_drive    = talk_mode ? nxt.data_drive : gpib_hs_pkg::BYTE_RELEASED;
    res.busy_res     = (nxt.phase != gpib_hs_pkg::PH_IDLE);
    res.event_res    = evt;
    res.rx_value     = nxt.latched_byte;
    res.rx_atn_level = nxt.latched_atn;
    res.rx_eoi_level = nxt.latched_eoi;
    res.cmd_type     = ctype;
    res.cmd_address  = caddr;
  end

endmodule

/* rtl/gpib_device_handshake_engine.sv */
// ----------------------------------------------------------------------------
// gpib_device_handshake_engine
// Device-side IEEE-488 three-wire handshake: command and data accept,
// release and reject as listener, byte send as talker.
// ----------------------------------------------------------------------------
//
//  channel  | dir | transaction
//  ---------+-----+--------------------------------------------------------
//  in_ch    | in  | one bus sample tick with an optional request
//  out_ch   | out | driven line levels, status, event and latched byte
//  cfg_*    | in  | register write: talk_mode (0), settle_ticks (1)
//
//  One tick per cycle while out_ch does not stall; a taken tick passes the
//  input register, then the result register, with the step logic between.
//  Engine state updates when a tick moves into the result register.
//  Synchronous reset releases all lines and clears state; no clearing pass.
//  A stall on out_ch holds both stages; in_ch stays ready while a stage frees.
//
module gpib_device_handshake_engine (
  input  logic                                clk,
  input  logic                                rst,
  gpib_hs_in_if.sink                          in_ch,
  gpib_hs_out_if.source                       out_ch,
  input  logic                                cfg_we,
  input  logic [gpib_hs_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [gpib_hs_pkg::CfgDatW-1:0]     cfg_data
);

  // configuration registers
  logic                              talk_mode;
  logic [gpib_hs_pkg::SettleW-1:0]   settle_ticks;

  // engine state
  gpib_hs_pkg::state_t  st;
  gpib_hs_pkg::state_t  st_next;
  gpib_hs_pkg::state_t  st_reset;

  // pipeline
  logic                  in_valid;
  gpib_hs_pkg::item_t    in_item;
  logic                  out_valid;
  gpib_hs_pkg::result_t  out_res;
  gpib_hs_pkg::result_t  res_next;
  logic                  advance;
  logic                  in_fire;
  logic                  step_fire;
  logic                  mode_change;

  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = !in_valid || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign step_fire   = in_valid && advance;
  assign mode_change = cfg_we && (cfg_index == gpib_hs_pkg::REG_TALK_MODE)
                       && (cfg_data[0] != talk_mode);

  // reset value of the engine state
  always_comb begin
    st_reset              = gpib_hs_pkg::released_state(st);
    st_reset.latched_byte = '0;
    st_reset.latched_atn  = 1'b1;
    st_reset.latched_eoi  = 1'b1;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      talk_mode    <= 1'b0;
      settle_ticks <= gpib_hs_pkg::SETTLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gpib_hs_pkg::REG_TALK_MODE:    talk_mode    <= cfg_data[0];
        gpib_hs_pkg::REG_SETTLE_TICKS: settle_ticks <= cfg_data[gpib_hs_pkg::SettleW-1:0];
        default: begin
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_reset;
    end else if (mode_change) begin
      st <= gpib_hs_pkg::released_state(st);
    end else if (step_fire) begin
      st <= st_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item.kind    <= in_ch.kind;
      in_item.dio_in  <= in_ch.dio_in;
      in_item.atn_in  <= in_ch.atn_in;
      in_item.dav_in  <= in_ch.dav_in;
      in_item.ndac_in <= in_ch.ndac_in;
      in_item.nrfd_in <= in_ch.nrfd_in;
      in_item.eoi_in  <= in_ch.eoi_in;
      in_item.tx_byte <= in_ch.tx_byte;
      in_item.tx_eoi  <= in_ch.tx_eoi;
    end
  end

  // one tick of handshake logic
  gpib_hs_step u_step (
    .st           (st),
    .item         (in_item),
    .talk_mode    (talk_mode),
    .settle_ticks (settle_ticks),
    .st_next      (st_next),
    .res          (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_res <= res_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.ndac_drive   = out_res.ndac_drive;
  assign out_ch.nrfd_drive   = out_res.nrfd_drive;
  assign out_ch.dav_drive    = out_res.dav_drive;
  assign out_ch.eoi_drive    = out_res.eoi_drive;
  assign out_ch.dio_drive    = out_res.dio_drive;
  assign out_ch.busy_res     = out_res.busy_res;
  assign out_ch.event_res    = out_res.event_res;
  assign out_ch.rx_value     = out_res.rx_value;
  assign out_ch.rx_atn_level = out_res.rx_atn_level;
  assign out_ch.rx_eoi_level = out_res.rx_eoi_level;
  assign out_ch.cmd_type     = out_res.cmd_type;
  assign out_ch.cmd_address  = out_res.cmd_address;

  // a mode flip always leaves the engine idle with lines released
  a_mode_change_idle: assert property (@(posedge clk) disable iff (rst)
    mode_change |=> (st.phase == gpib_hs_pkg::PH_IDLE) && st.ndac_level && st.dav_level
                    && (st.data_drive == gpib_hs_pkg::BYTE_RELEASED))
    else $error("mode change did not abort the sequence");

  // settle counter only runs inside the settle wait
  a_settle_scope: assert property (@(posedge clk) disable iff (rst)
    (st.phase != gpib_hs_pkg::PH_SETTLE) |-> (st.settle_count == '0))
    else $error("settle counter live outside settle wait");

  // command fields only carry meaning on a command event
  a_cmd_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.event_res != gpib_hs_pkg::EV_CMD)) |->
      ((out_res.cmd_type == gpib_hs_pkg::CMD_UNKNOWN) && (out_res.cmd_address == '0)))
    else $error("command fields set without command event");

  // an event always closes its sequence
  a_event_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.event_res != gpib_hs_pkg::EV_NONE)) |-> !out_res.busy_res)
    else $error("event reported while sequence still running");

endmodule

/* test/gpib_hs_handshake_check.sv */
// ----------------------------------------------------------------------------
// gpib_hs_handshake_check
// Watches the tick and result channels of the GPIB handshake engine, keeps
// its own copy of the engine and its registers, predicts one result per
// accepted tick and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module gpib_hs_handshake_check (
  input  logic                            clk,
  input  logic                            rst,
  gpib_hs_in_if                           in_ch,
  gpib_hs_out_if                          out_ch,
  input  logic                            cfg_we,
  input  logic [gpib_hs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gpib_hs_pkg::CfgDatW-1:0] cfg_data,
  output int                              pending,
  output int                              mismatches,
  output int                              results_seen,
  output int                              cmds_seen,
  output int                              data_seen,
  output int                              sends_seen,
  output int                              releases_seen
);
  import gpib_hs_pkg::*;

  // register copy
  logic               talker;
  logic [SettleW-1:0] settle_cfg;

  // engine copy
  phase_t             ph;
  logic [SettleW-1:0] settle_left;
  logic               ndac_q;
  logic               nrfd_q;
  logic               dav_q;
  logic               eoi_q;
  logic [ByteW-1:0]   dio_q;
  logic [ByteW-1:0]   rx_byte;
  logic               rx_atn;
  logic               rx_eoi;

  result_t due_results[$];
  int      bad;
  int      seen;
  int      n_cmd;
  int      n_data;
  int      n_sent;
  int      n_rel;

  // let go of every driven line
  function automatic void release_bus();
    ndac_q = 1'b1;
    nrfd_q = 1'b1;
    dav_q  = 1'b1;
    eoi_q  = 1'b1;
    dio_q  = BYTE_RELEASED;
  endfunction

  // command byte classification, logical polarity
  function automatic void classify(input logic [ByteW-1:0] b, output cmd_t t,
                                   output logic [AddrW-1:0] a);
    a = '0;
    case (b)
      BYTE_DCL: t = CMD_DCL;
      BYTE_SPE: t = CMD_SPE;
      BYTE_SPD: t = CMD_SPD;
      BYTE_UNL: t = CMD_UNL;
      BYTE_UNT: t = CMD_UNT;
      default: begin
        if ((b & GROUP_MASK) == GROUP_LISTEN) begin
          t = CMD_MLA;
          a = b[AddrW-1:0];
        end else if ((b & GROUP_MASK) == GROUP_TALK) begin
          t = CMD_MTA;
          a = b[AddrW-1:0];
        end else begin
          t = CMD_UNKNOWN;
        end
      end
    endcase
  endfunction

  // advance the engine copy by one tick and form its result
  function automatic result_t step_engine(input item_t t);
    result_t          r;
    event_t           ev;
    cmd_t             ct;
    logic [AddrW-1:0] ca;
    logic             placed;
    ev     = EV_NONE;
    ct     = CMD_UNKNOWN;
    ca     = '0;
    placed = 1'b0;
    // requests only start from idle and in the matching mode
    if (ph == PH_IDLE) begin
      if (!talker) begin
        case (t.kind)
          KIND_CMD: ph = PH_CMD;
          KIND_DATA: begin
            ndac_q = 1'b0;
            ph     = PH_DATA;
          end
          KIND_FINISH: begin
            nrfd_q = 1'b0;
            ndac_q = 1'b1;
            ph     = PH_FINISH;
          end
          KIND_REJECT: begin
            ndac_q = 1'b1;
            ph     = PH_REJECT;
          end
          default: ;
        endcase
      end else if (t.kind == KIND_SEND) begin
        eoi_q       = ~t.tx_eoi;
        dio_q       = ~t.tx_byte;
        settle_left = settle_cfg;
        ph          = PH_SETTLE;
        placed      = 1'b1;
      end
    end
    // listener waits test the request tick itself; settle starts next tick
    if (!placed) begin
      case (ph)
        PH_CMD: begin
          if (t.atn_in) begin
            ndac_q = 1'b1;
          end else begin
            ndac_q = 1'b0;
            if (!t.dav_in) begin
              nrfd_q  = 1'b0;
              rx_byte = ~t.dio_in;
              classify(rx_byte, ct, ca);
              ev = EV_CMD;
              ph = PH_IDLE;
            end
          end
        end
        PH_DATA: begin
          if (!t.dav_in) begin
            rx_byte = ~t.dio_in;
            rx_atn  = t.atn_in;
            rx_eoi  = t.eoi_in;
            ev      = EV_DATA;
            ph      = PH_IDLE;
          end
        end
        PH_FINISH: begin
          if (t.dav_in) begin
            ndac_q = 1'b0;
            nrfd_q = 1'b1;
            ev     = EV_RELEASED;
            ph     = PH_IDLE;
          end
        end
        PH_REJECT: begin
          if (t.dav_in) begin
            nrfd_q = 1'b1;
            ev     = EV_RELEASED;
            ph     = PH_IDLE;
          end
        end
        PH_SETTLE: begin
          if (settle_left != '0) begin
            settle_left = settle_left - 1'b1;
          end else if (!t.ndac_in && t.nrfd_in) begin
            dav_q = 1'b0;
            ph    = PH_ACCEPT;
          end
        end
        PH_ACCEPT: begin
          if (t.ndac_in) begin
            dav_q = 1'b1;
            eoi_q = 1'b1;
            ev    = EV_SENT;
            ph    = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    // lines of the inactive role read as released
    r.ndac_drive   = talker ? 1'b1 : ndac_q;
    r.nrfd_drive   = talker ? 1'b1 : nrfd_q;
    r.dav_drive    = talker ? dav_q : 1'b1;
    r.eoi_drive    = talker ? eoi_q : 1'b1;
    r.dio_drive    = talker ? dio_q : BYTE_RELEASED;
    r.busy_res     = (ph != PH_IDLE);
    r.event_res    = ev;
    r.rx_value     = rx_byte;
    r.rx_atn_level = rx_atn;
    r.rx_eoi_level = rx_eoi;
    r.cmd_type     = ct;
    r.cmd_address  = ca;
    return r;
  endfunction

  // list of differing fields as " name expected/actual"
  function automatic string field_diffs(input result_t e, input result_t g);
    string s;
    s = "";
    if (g.ndac_drive !== e.ndac_drive)
      s = {s, $sformatf(" ndac_drive %0h/%0h", e.ndac_drive, g.ndac_drive)};
    if (g.nrfd_drive !== e.nrfd_drive)
      s = {s, $sformatf(" nrfd_drive %0h/%0h", e.nrfd_drive, g.nrfd_drive)};
    if (g.dav_drive !== e.dav_drive)
      s = {s, $sformatf(" dav_drive %0h/%0h", e.dav_drive, g.dav_drive)};
    if (g.eoi_drive !== e.eoi_drive)
      s = {s, $sformatf(" eoi_drive %0h/%0h", e.eoi_drive, g.eoi_drive)};
    if (g.dio_drive !== e.dio_drive)
      s = {s, $sformatf(" dio_drive %0h/%0h", e.dio_drive, g.dio_drive)};
    if (g.busy_res !== e.busy_res)
      s = {s, $sformatf(" busy_res %0h/%0h", e.busy_res, g.busy_res)};
    if (g.event_res !== e.event_res)
      s = {s, $sformatf(" event_res %0h/%0h", e.event_res, g.event_res)};
    if (g.rx_value !== e.rx_value)
      s = {s, $sformatf(" rx_value %0h/%0h", e.rx_value, g.rx_value)};
    if (g.rx_atn_level !== e.rx_atn_level)
      s = {s, $sformatf(" rx_atn_level %0h/%0h", e.rx_atn_level, g.rx_atn_level)};
    if (g.rx_eoi_level !== e.rx_eoi_level)
      s = {s, $sformatf(" rx_eoi_level %0h/%0h", e.rx_eoi_level, g.rx_eoi_level)};
    if (g.cmd_type !== e.cmd_type)
      s = {s, $sformatf(" cmd_type %0h/%0h", e.cmd_type, g.cmd_type)};
    if (g.cmd_address !== e.cmd_address)
      s = {s, $sformatf(" cmd_address %0h/%0h", e.cmd_address, g.cmd_address)};
    return s;
  endfunction

  // register writes, result compare, then tick prediction
  always @(posedge clk) begin
    item_t   tick;
    result_t want;
    result_t got;
    string   diffs;
    if (rst) begin
      talker      = 1'b0;
      settle_cfg  = SETTLE_RESET;
      ph          = PH_IDLE;
      settle_left = '0;
      release_bus();
      rx_byte     = '0;
      rx_atn      = 1'b1;
      rx_eoi      = 1'b1;
      due_results.delete();
      bad    = 0;
      seen   = 0;
      n_cmd  = 0;
      n_data = 0;
      n_sent = 0;
      n_rel  = 0;
    end else begin
      // a mode change aborts any sequence and releases the bus
      if (cfg_we) begin
        case (cfg_index)
          REG_TALK_MODE: begin
            if (cfg_data[0] != talker) begin
              talker      = cfg_data[0];
              ph          = PH_IDLE;
              settle_left = '0;
              release_bus();
            end
          end
          REG_SETTLE_TICKS: settle_cfg = cfg_data[SettleW-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got.ndac_drive   = out_ch.ndac_drive;
        got.nrfd_drive   = out_ch.nrfd_drive;
        got.dav_drive    = out_ch.dav_drive;
        got.eoi_drive    = out_ch.eoi_drive;
        got.dio_drive    = out_ch.dio_drive;
        got.busy_res     = out_ch.busy_res;
        got.event_res    = event_t'(out_ch.event_res);
        got.rx_value     = out_ch.rx_value;
        got.rx_atn_level = out_ch.rx_atn_level;
        got.rx_eoi_level = out_ch.rx_eoi_level;
        got.cmd_type     = cmd_t'(out_ch.cmd_type);
        got.cmd_address  = out_ch.cmd_address;
        seen++;
        if (due_results.size() == 0) begin
          bad++;
          if (bad <= 10) $display("result %0d arrived with none expected: %p", seen, got);
        end else begin
          want  = due_results.pop_front();
          diffs = field_diffs(want, got);
          if (diffs != "") begin
            bad++;
            if (bad <= 10) $display("result %0d wrong (expected/actual):%s", seen, diffs);
          end
          case (want.event_res)
            EV_CMD:      n_cmd++;
            EV_DATA:     n_data++;
            EV_SENT:     n_sent++;
            EV_RELEASED: n_rel++;
            default: ;
          endcase
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        tick.kind    = in_ch.kind;
        tick.dio_in  = in_ch.dio_in;
        tick.atn_in  = in_ch.atn_in;
        tick.dav_in  = in_ch.dav_in;
        tick.ndac_in = in_ch.ndac_in;
        tick.nrfd_in = in_ch.nrfd_in;
        tick.eoi_in  = in_ch.eoi_in;
        tick.tx_byte = in_ch.tx_byte;
        tick.tx_eoi  = in_ch.tx_eoi;
        due_results.push_back(step_engine(tick));
      end
    end
    pending       <= due_results.size();
    mismatches    <= bad;
    results_seen  <= seen;
    cmds_seen     <= n_cmd;
    data_seen     <= n_data;
    sends_seen    <= n_sent;
    releases_seen <= n_rel;
  end

endmodule

/* test/gpib_device_handshake_engine_tb.sv */
// ----------------------------------------------------------------------------
// gpib_device_handshake_engine_tb
// Drives bus ticks and register writes into the GPIB handshake engine: a
// directed pass over each request, each named command byte, corner cases, then
// random ticks in listener and talker mode with random gaps and stalls and
// one long receiver hold-off. The checker beside the block gives the count.
// ----------------------------------------------------------------------------
module gpib_device_handshake_engine_tb;
  import gpib_hs_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int LONG_SETTLE = 150;

  localparam logic             MODE_LISTEN = 1'b0;
  localparam logic             MODE_TALK   = 1'b1;
  localparam logic [KindW-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KindW-1:0] KIND_SPARE7 = 3'd7;

  localparam logic [KindW-1:0] LISTEN_REQS [4] = '{KIND_CMD, KIND_DATA, KIND_FINISH,
                                                  KIND_REJECT};
  // commands after DCL, including both address groups, bit 7 set, and unknowns
  localparam logic [ByteW-1:0] CMD_PROBES [9] = '{BYTE_SPE, BYTE_SPD, BYTE_UNL, BYTE_UNT,
                                                 GROUP_LISTEN | 8'h1E, GROUP_TALK,
                                                 8'h00, 8'hFF, 8'hDF};

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDatW-1:0] cfg_data;

  int pending;
  int mismatches;
  int results_seen;
  int cmds_seen;
  int data_seen;
  int sends_seen;
  int releases_seen;
  int ticks_sent;
  int cycles;
  bit steady;

  gpib_hs_in_if  in_ch ();
  gpib_hs_out_if out_ch ();

  gpib_device_handshake_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gpib_hs_handshake_check u_check (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .mismatches    (mismatches),
    .results_seen  (results_seen),
    .cmds_seen     (cmds_seen),
    .data_seen     (data_seen),
    .sends_seen    (sends_seen),
    .releases_seen (releases_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycles, pending);
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random stalls, one long hold-off, none in the steady tail
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= 80) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic put_fields(input item_t t);
    in_ch.kind    <= t.kind;
    in_ch.dio_in  <= t.dio_in;
    in_ch.atn_in  <= t.atn_in;
    in_ch.dav_in  <= t.dav_in;
    in_ch.ndac_in <= t.ndac_in;
    in_ch.nrfd_in <= t.nrfd_in;
    in_ch.eoi_in  <= t.eoi_in;
    in_ch.tx_byte <= t.tx_byte;
    in_ch.tx_eoi  <= t.tx_eoi;
  endtask

  // present one tick and hold it until the engine takes it
  task automatic offer_tick(input item_t t);
    in_ch.valid <= 1'b1;
    put_fields(t);
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
  endtask

  // random input gap, none in the steady tail
  task automatic pause_input();
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic bus_tick(input logic [KindW-1:0] kind, input logic [ByteW-1:0] dio,
                          input logic atn, input logic dav, input logic ndac,
                          input logic nrfd, input logic eoi,
                          input logic [ByteW-1:0] txb, input logic txe);
    item_t t;
    t = '{kind, dio, atn, dav, ndac, nrfd, eoi, txb, txe};
    offer_tick(t);
    pause_input();
  endtask

  // stop ticks and wait until every result is out and the pipeline is empty
  task automatic drain_engine();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // logical command byte, mostly recognized ones
  function automatic logic [ByteW-1:0] command_byte();
    logic [ByteW-1:0] b;
    case ($urandom_range(0, 7))
      0: b = BYTE_DCL;
      1: b = BYTE_SPE;
      2: b = BYTE_SPD;
      3: b = BYTE_UNL;
      4: b = BYTE_UNT;
      5: b = GROUP_LISTEN | (ADDR_MASK & 8'($urandom)) | (8'h80 & 8'($urandom));
      6: b = GROUP_TALK | (ADDR_MASK & 8'($urandom)) | (8'h80 & 8'($urandom));
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // random tick: half plain ticks, mostly mode-matched requests, some noise
  function automatic item_t random_tick(input bit talk);
    item_t t;
    int    pick;
    t.dio_in  = $urandom_range(0, 1) ? ~command_byte() : 8'($urandom);
    t.atn_in  = 1'($urandom_range(0, 1));
    t.dav_in  = 1'($urandom_range(0, 1));
    t.ndac_in = 1'($urandom_range(0, 1));
    t.nrfd_in = 1'($urandom_range(0, 1));
    t.eoi_in  = 1'($urandom_range(0, 1));
    t.tx_byte = 8'($urandom);
    t.tx_eoi  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 50)      t.kind = KIND_TICK;
    else if (pick < 85) t.kind = talk ? KIND_SEND : LISTEN_REQS[2'($urandom_range(0, 3))];
    else                t.kind = 3'($urandom_range(0, 7));
    return t;
  endfunction

  task automatic run_random(input int n, input bit talk);
    repeat (n) begin
      offer_tick(random_tick(talk));
      pause_input();
    end
  endtask

  // stimulus
  initial begin
    item_t t;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_TALK_MODE;
    cfg_data   <= '0;
    in_ch.valid <= 1'b0;
    put_fields('0);
    steady     = 1'b0;
    ticks_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // command accept: wait for ATN, then DAV, then latch DCL
    bus_tick(KIND_CMD,  ~BYTE_DCL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
    bus_tick(KIND_TICK, ~BYTE_DCL, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
    bus_tick(KIND_TICK, ~BYTE_DCL, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
    // remaining commands latched on the request tick
    foreach (CMD_PROBES[i])
      bus_tick(KIND_CMD, ~CMD_PROBES[i], 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
    // data accept, with a command request ignored while busy
    bus_tick(KIND_DATA, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
    bus_tick(KIND_CMD,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    bus_tick(KIND_DATA, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
    // finish waits for DAV high, reject sees it at once
    bus_tick(KIND_FINISH, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
    bus_tick(KIND_TICK,   8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
    bus_tick(KIND_REJECT, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
    // send in listener mode and unused kinds do nothing
    bus_tick(KIND_SEND,   8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1);
    bus_tick(KIND_SPARE6, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
    bus_tick(KIND_SPARE7, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);

    // talker with no settle wait: place, DAV low, then NDAC release
    drain_engine();
    write_reg(REG_SETTLE_TICKS, '0);
    write_reg(REG_TALK_MODE, MODE_TALK);
    bus_tick(KIND_SEND, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1);
    bus_tick(KIND_TICK, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
    bus_tick(KIND_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0);
    // listener request ignored in talker mode
    bus_tick(KIND_CMD,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);

    // random listener traffic; the receiver hold-off falls in here
    drain_engine();
    write_reg(REG_TALK_MODE, MODE_LISTEN);
    write_reg(REG_SETTLE_TICKS, CfgDatW'($urandom_range(0, LONG_SETTLE)));
    run_random(100, 1'b0);
    // rewriting the same mode must not abort a running sequence
    drain_engine();
    write_reg(REG_TALK_MODE, MODE_LISTEN);
    run_random(40, 1'b0);

    // random talker traffic with no settle wait
    drain_engine();
    write_reg(REG_SETTLE_TICKS, '0);
    write_reg(REG_TALK_MODE, MODE_TALK);
    run_random(90, 1'b1);

    // one send through a long settle wait
    drain_engine();
    write_reg(REG_SETTLE_TICKS, CfgDatW'(LONG_SETTLE));
    t = random_tick(1'b1);
    t.kind = KIND_SEND;
    offer_tick(t);
    pause_input();
    repeat (LONG_SETTLE) begin
      t = random_tick(1'b1);
      t.kind = KIND_TICK;
      offer_tick(t);
      pause_input();
    end
    bus_tick(KIND_TICK, 8'h5A, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'hA5, 1'b1);
    bus_tick(KIND_TICK, 8'hA5, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'h5A, 1'b0);

    // short settle waits
    drain_engine();
    write_reg(REG_SETTLE_TICKS, CfgDatW'($urandom_range(1, 4)));
    run_random(70, 1'b1);

    // steady tail in listener mode, mode change may abort a send
    drain_engine();
    steady = 1'b1;
    write_reg(REG_TALK_MODE, MODE_LISTEN);
    run_random(60, 1'b0);

    drain_engine();
    $display("%0d bus ticks, %0d results: %0d commands, %0d data bytes, %0d sends, %0d releases",
             ticks_sent, results_seen, cmds_seen, data_seen, sends_seen, releases_seen);
    $display("listener and talker modes, settle 0 to %0d, %0d-cycle receiver hold-off",
             LONG_SETTLE, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/gpib_hs_pkg.sv
rtl/gpib_hs_if.sv
rtl/gpib_hs_step.sv
rtl/gpib_device_handshake_engine.sv
test/gpib_hs_handshake_check.sv
test/gpib_device_handshake_engine_tb.sv
